>>> sv/ppd_pkg.sv
`timescale 1ns / 1ps
// ppd_pkg: widths, root-stage state type and the root digit step for the
// point pair distance core. No dependencies.
package ppd_pkg;

    localparam int COORD_W      = 16;               // coordinate width, 8 fraction bits
    localparam int DIFF_W       = COORD_W + 1;      // signed difference
    localparam int MAG_W        = COORD_W;          // |difference| fits here
    localparam int SQ_W         = 2 * MAG_W;        // one square
    localparam int SUM_W        = SQ_W + 1;         // sum of two squares
    localparam int ROOT_W       = (SUM_W + 1) / 2;  // full integer root
    localparam int RAD_W        = 2 * ROOT_W;       // radicand padded to even width
    localparam int REM_W        = ROOT_W + 2;       // partial remainder
    localparam int DIST_W       = 17;               // distance port width
    localparam int BITS_PER_STG = 3;                // root bits resolved per stage
    localparam int SQRT_STG     = (ROOT_W + BITS_PER_STG - 1) / BITS_PER_STG;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } t_root_st;

    // One restoring square-root digit: bring down two radicand bits,
    // try subtracting (4*root + 1).
    function automatic t_root_st root_step(input t_root_st s);
        logic [REM_W:0] rem_t;
        logic [REM_W:0] trial;
        logic           ge;
        t_root_st       n;
        rem_t  = {s.rem[REM_W-2:0], s.rad[RAD_W-1 -: 2]};
        trial  = {1'b0, s.root, 2'b01};
        ge     = (rem_t >= trial);
        n.rem  = ge ? REM_W'(rem_t - trial) : REM_W'(rem_t);
        n.root = {s.root[ROOT_W-2:0], ge};
        n.rad  = {s.rad[RAD_W-3:0], 2'b00};
        return n;
    endfunction

endpackage

>>> sv/point_pair_distance_core.sv
`timescale 1ns / 1ps
// point_pair_distance_core: floor(sqrt(dx^2 + dy^2)) per transaction.
// Registered path: 3 front stages, then 6 root stages, from accepted input
// to valid output. Throughput: one transaction per cycle when no stall holds;
// a full stage holds while the one after it holds, chained combinationally.
// Reset (i_rst_n low, synchronous) clears only the stage valid bits.
// Depends on ppd_pkg, ppd_sq_front, ppd_sqrt_pipe.
module point_pair_distance_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [ppd_pkg::COORD_W-1:0] i_x_start,
    input  logic signed [ppd_pkg::COORD_W-1:0] i_x_end,
    input  logic signed [ppd_pkg::COORD_W-1:0] i_y_start,
    input  logic signed [ppd_pkg::COORD_W-1:0] i_y_end,
    input  logic                               i_last_in,
    // output channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [ppd_pkg::DIST_W-1:0]         o_distance,
    output logic                               o_last_out
);
    import ppd_pkg::*;

    // front end -> root pipe
    logic              w_mid_valid;
    logic              w_mid_stall;
    logic [SUM_W-1:0]  w_mid_sum;
    logic              w_mid_last;
    logic [ROOT_W-1:0] w_root;

    // Differences, magnitudes, squares and the exact sum. The sum keeps
    // all 16 fraction bits, so its root carries exactly 8.
    ppd_sq_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_x_start (i_x_start),
        .i_x_end   (i_x_end),
        .i_y_start (i_y_start),
        .i_y_end   (i_y_end),
        .i_last    (i_last_in),
        .o_valid   (w_mid_valid),
        .i_stall   (w_mid_stall),
        .o_sum     (w_mid_sum),
        .o_last    (w_mid_last)
    );

    // Truncating root; its last stage is the output register, so a
    // waiting result does not block the stages behind it from filling.
    ppd_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mid_valid),
        .o_stall (w_mid_stall),
        .i_sum   (w_mid_sum),
        .i_last  (w_mid_last),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_root  (w_root),
        .o_last  (o_last_out)
    );

    // Root fits the port for 16-bit coordinates; wider ones wrap.
    assign o_distance = DIST_W'(w_root);

endmodule

>>> sv/ppd_sq_front.sv
`timescale 1ns / 1ps
// ppd_sq_front: three-stage front end, |dx| and |dy|, squares, sum.
// Depends on ppd_pkg.
module ppd_sq_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [ppd_pkg::COORD_W-1:0] i_x_start,
    input  logic signed [ppd_pkg::COORD_W-1:0] i_x_end,
    input  logic signed [ppd_pkg::COORD_W-1:0] i_y_start,
    input  logic signed [ppd_pkg::COORD_W-1:0] i_y_end,
    input  logic                               i_last,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [ppd_pkg::SUM_W-1:0]          o_sum,
    output logic                               o_last
);
    import ppd_pkg::*;

    logic [2:0] r_v;
    logic [2:0] r_last;
    logic [3:0] w_stall;

    logic signed [DIFF_W-1:0] w_dx;
    logic signed [DIFF_W-1:0] w_dy;
    logic [MAG_W-1:0]         n_magx;
    logic [MAG_W-1:0]         n_magy;
    logic [MAG_W-1:0]         r_magx;
    logic [MAG_W-1:0]         r_magy;
    logic [SQ_W-1:0]          r_sqx;
    logic [SQ_W-1:0]          r_sqy;
    logic [SUM_W-1:0]         r_sum;

    // stage k holds when it is full and the stage after it holds
    assign w_stall[3] = i_stall;
    assign w_stall[2] = r_v[2] & w_stall[3];
    assign w_stall[1] = r_v[1] & w_stall[2];
    assign w_stall[0] = r_v[0] & w_stall[1];
    assign o_stall    = w_stall[0];

    always_comb begin
        w_dx   = $signed({i_x_end[COORD_W-1], i_x_end})
               - $signed({i_x_start[COORD_W-1], i_x_start});
        w_dy   = $signed({i_y_end[COORD_W-1], i_y_end})
               - $signed({i_y_start[COORD_W-1], i_y_start});
        n_magx = w_dx[DIFF_W-1] ? MAG_W'(-w_dx) : MAG_W'(w_dx);
        n_magy = w_dy[DIFF_W-1] ? MAG_W'(-w_dy) : MAG_W'(w_dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (!w_stall[0]) r_v[0] <= i_valid;
            if (!w_stall[1]) r_v[1] <= r_v[0];
            if (!w_stall[2]) r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall[0]) begin
            r_magx    <= n_magx;
            r_magy    <= n_magy;
            r_last[0] <= i_last;
        end
        if (!w_stall[1]) begin
            r_sqx     <= r_magx * r_magx;
            r_sqy     <= r_magy * r_magy;
            r_last[1] <= r_last[0];
        end
        if (!w_stall[2]) begin
            r_sum     <= SUM_W'(r_sqx) + SUM_W'(r_sqy);
            r_last[2] <= r_last[1];
        end
    end

    assign o_valid = r_v[2];
    assign o_sum   = r_sum;
    assign o_last  = r_last[2];

endmodule

>>> sv/ppd_sqrt_pipe.sv
`timescale 1ns / 1ps
// ppd_sqrt_pipe: pipelined restoring integer square root, up to BITS_PER_STG
// root bits per stage. Depends on ppd_pkg.
module ppd_sqrt_pipe (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ppd_pkg::SUM_W-1:0]   i_sum,
    input  logic                        i_last,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ppd_pkg::ROOT_W-1:0]  o_root,
    output logic                        o_last
);
    import ppd_pkg::*;

    logic [SQRT_STG-1:0] r_v;
    logic [SQRT_STG-1:0] r_last;
    logic [SQRT_STG:0]   w_stall;
    t_root_st            r_st [SQRT_STG];
    t_root_st            n_st [SQRT_STG];
    t_root_st            w_init;

    assign w_stall[SQRT_STG] = i_stall;
    assign o_stall           = w_stall[0];

    always_comb begin
        w_init.rem  = '0;
        w_init.root = '0;
        w_init.rad  = RAD_W'(i_sum);
    end

    for (genvar s = 0; s < SQRT_STG; s++) begin : g_stg
        logic     w_vin;
        logic     w_lin;
        t_root_st w_sin;

        if (s == 0) begin : g_first
            assign w_vin = i_valid;
            assign w_lin = i_last;
            assign w_sin = w_init;
        end else begin : g_rest
            assign w_vin = r_v[s-1];
            assign w_lin = r_last[s-1];
            assign w_sin = r_st[s-1];
        end

        assign w_stall[s] = r_v[s] & w_stall[s+1];

        always_comb begin
            t_root_st v;
            v = w_sin;
            for (int j = 0; j < BITS_PER_STG; j++) begin
                if (s * BITS_PER_STG + j < ROOT_W) v = root_step(v);
            end
            n_st[s] = v;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (!w_stall[s]) begin
                r_v[s] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!w_stall[s]) begin
                r_st[s]   <= n_st[s];
                r_last[s] <= w_lin;
            end
        end
    end

    assign o_valid = r_v[SQRT_STG-1];
    assign o_root  = r_st[SQRT_STG-1].root;
    assign o_last  = r_last[SQRT_STG-1];

endmodule

>>> sim/tb_point_pair_distance_core.sv
`timescale 1ns / 1ps
// tb_point_pair_distance_core: self-checking testbench for the point pair distance core.
// It predicts floor(sqrt(dx^2 + dy^2)) for each point pair and compares every output.
// Depends on ppd_pkg and point_pair_distance_core.
module tb_point_pair_distance_core;
    import ppd_pkg::*;

    localparam int N_RANDOM = 1830;    // floor(N_RANDOM / N_PHASES) random pairs per phase, after the directed table
    localparam int N_PHASES = 4;

    // ------------------------------------------------------------------
    // DUT signals; every input starts from a known value
    // ------------------------------------------------------------------
    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_valid     = 1'b0;
    logic                      o_stall;
    logic signed [COORD_W-1:0] i_x_start   = '0;
    logic signed [COORD_W-1:0] i_x_end     = '0;
    logic signed [COORD_W-1:0] i_y_start   = '0;
    logic signed [COORD_W-1:0] i_y_end     = '0;
    logic                      i_last_in   = 1'b0;
    logic                      o_valid;
    logic                      i_stall     = 1'b0;
    logic [DIST_W-1:0]         o_distance;
    logic                      o_last_out;

    point_pair_distance_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_x_start  (i_x_start),
        .i_x_end    (i_x_end),
        .i_y_start  (i_y_start),
        .i_y_end    (i_y_end),
        .i_last_in  (i_last_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_distance (o_distance),
        .o_last_out (o_last_out)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Expected results, oldest first
    // ------------------------------------------------------------------
    typedef struct {
        logic [DIST_W-1:0] dist_val;
        logic              last;
    } t_dist_exp;

    t_dist_exp dist_expected[$];

    int mismatches    = 0;
    int pairs_sent    = 0;
    int dists_checked = 0;
    int src_idle_pct  = 0;   // chance per cycle that the sender holds valid low
    int sink_stall_pct = 0;  // chance per cycle that the receiver stalls

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Distance predictor: exact sum of squares, root truncated by a
    // bit-by-bit search. Root of 2*65535^2 is below 2^17.
    function automatic logic [DIST_W-1:0] pair_distance(
        input logic signed [COORD_W-1:0] xs,
        input logic signed [COORD_W-1:0] xe,
        input logic signed [COORD_W-1:0] ys,
        input logic signed [COORD_W-1:0] ye
    );
        longint          dx;
        longint          dy;
        longint unsigned sum_sq;
        longint unsigned root;
        longint unsigned trial;
        dx = longint'(xe) - longint'(xs);
        dy = longint'(ye) - longint'(ys);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        sum_sq = longint'(dx * dx) + longint'(dy * dy);
        root   = 0;
        for (int b = 17; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sum_sq) root = trial;
        end
        return root[DIST_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Sender: one point pair per call. Valid only drops while idling, so
    // back-to-back transactions keep it high without a glitch.
    // ------------------------------------------------------------------
    task automatic send_pair(
        input logic signed [COORD_W-1:0] xs,
        input logic signed [COORD_W-1:0] xe,
        input logic signed [COORD_W-1:0] ys,
        input logic signed [COORD_W-1:0] ye,
        input logic                      last,
        input bit                        known,
        input logic [DIST_W-1:0]         known_dist
    );
        t_dist_exp e;
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_x_start <= xs;
        i_x_end   <= xe;
        i_y_start <= ys;
        i_y_end   <= ye;
        i_last_in <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // accepted at this edge
        e.dist_val = known ? known_dist : pair_distance(xs, xe, ys, ye);
        e.last     = last;
        dist_expected.push_back(e);
        pairs_sent++;
    endtask

    // Random point pairs, weighted toward the interesting corners
    task automatic send_random_pair();
        logic signed [COORD_W-1:0] xs;
        logic signed [COORD_W-1:0] xe;
        logic signed [COORD_W-1:0] ys;
        logic signed [COORD_W-1:0] ye;
        int                        pick;
        xs   = COORD_W'($urandom);
        xe   = COORD_W'($urandom);
        ys   = COORD_W'($urandom);
        ye   = COORD_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 15) begin
            // nearby points: short distances, fraction bits matter
            xe = xs + COORD_W'($urandom_range(64) - 32);
            ye = ys + COORD_W'($urandom_range(64) - 32);
        end else if (pick < 27) begin
            // coordinates pinned at the rails
            xs = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            xe = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            if ($urandom_range(1)) ys = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            if ($urandom_range(1)) ye = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        end else if (pick < 35) begin
            // equal points
            xe = xs;
            ye = ys;
        end else if (pick < 42) begin
            // one axis only
            if ($urandom_range(1)) ye = ys;
            else                   xe = xs;
        end
        send_pair(xs, xe, ys, ye, ($urandom_range(7) == 0), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Receiver stall and output checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    always @(posedge i_clk) begin
        t_dist_exp e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (dist_expected.size() == 0) begin
                report_mismatch($sformatf("distance %0d with no transaction pending",
                                          o_distance));
            end else begin
                e = dist_expected.pop_front();
                dists_checked++;
                if (o_distance !== e.dist_val)
                    report_mismatch($sformatf("distance got %0d expected %0d",
                                              o_distance, e.dist_val));
                if (o_last_out !== e.last)
                    report_mismatch($sformatf("last got %b expected %b",
                                              o_last_out, e.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed table: corners and special cases. Where the distance is
    // obvious it is typed in; otherwise the predictor supplies it.
    // ------------------------------------------------------------------
    typedef struct {
        logic signed [COORD_W-1:0] xs;
        logic signed [COORD_W-1:0] xe;
        logic signed [COORD_W-1:0] ys;
        logic signed [COORD_W-1:0] ye;
        logic                      last;
        bit                        known;
        logic [DIST_W-1:0]         dist_val;
    } t_pair_row;

    localparam int N_DIRECTED = 16;

    t_pair_row directed_pairs[N_DIRECTED] = '{
        // both points at the origin
        '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 1'b1, 17'd0},
        // full diagonal span: largest distance
        '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1, 1'b1, 17'd92680},
        '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, 1'b1, 17'd92680},
        // full span on one axis
        '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0000, 1'b1, 1'b1, 17'd65535},
        '{16'sh0000, 16'sh0000, 16'sh8000, 16'sh7fff, 1'b0, 1'b1, 17'd65535},
        // 3-4-5 in raw units and scaled by 256
        '{16'sh0000, 16'sh0003, 16'sh0000, 16'sh0004, 1'b0, 1'b1, 17'd5},
        '{16'sh0000, 16'sh0300, 16'sh0000, 16'sh0400, 1'b1, 1'b1, 17'd1280},
        // equal points, including the rails
        '{16'sh3039, 16'sh3039, 16'shfff9, 16'shfff9, 1'b0, 1'b1, 17'd0},
        '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 1'b1, 1'b1, 17'd0},
        // one lsb apart; sqrt(2) lsb truncates to one
        '{16'sh0000, 16'sh0001, 16'sh0000, 16'sh0000, 1'b0, 1'b1, 17'd1},
        '{16'sh0000, 16'sh0001, 16'sh0000, 16'sh0001, 1'b0, 1'b1, 17'd1},
        '{16'shffff, 16'shfffe, 16'sh0005, 16'sh0005, 1'b1, 1'b1, 17'd1},
        // predictor rows
        '{16'sh03e8, 16'shf63c, 16'shfed4, 16'sh1000, 1'b0, 1'b0, 17'd0},
        '{16'sh8000, 16'shffff, 16'sh0064, 16'shff38, 1'b1, 1'b0, 17'd0},
        '{16'sh7fff, 16'sh0000, 16'sh8000, 16'sh0000, 1'b0, 1'b0, 17'd0},
        '{16'shffff, 16'sh5555, 16'shaaaa, 16'sh0000, 1'b1, 1'b0, 17'd0}
    };

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table within the first of four idle/stall phases
    // ------------------------------------------------------------------
    initial begin
        int idle_phase[N_PHASES]  = '{0, 48, 0, 36};
        int stall_phase[N_PHASES] = '{0, 0, 48, 36};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < N_PHASES; p++) begin
            src_idle_pct   = idle_phase[p];
            sink_stall_pct = stall_phase[p];
            if (p == 0) begin
                for (int r = 0; r < N_DIRECTED; r++)
                    send_pair(directed_pairs[r].xs, directed_pairs[r].xe,
                              directed_pairs[r].ys, directed_pairs[r].ye,
                              directed_pairs[r].last, directed_pairs[r].known,
                              directed_pairs[r].dist_val);
            end
            for (int n = 0; n < N_RANDOM / N_PHASES; n++)
                send_random_pair();
        end
        i_valid <= 1'b0;

        // drain, then give the pipeline time to show any extra output
        while (dist_expected.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d point pairs (%0d directed) over %0d idle/stall phases,",
                 pairs_sent, N_DIRECTED, N_PHASES);
        $display("checked %0d distances, %0d mismatches.", dists_checked, mismatches);
        if (mismatches == 0 && dist_expected.size() == 0) begin
            $display("tb_point_pair_distance_core passed");
        end else begin
            $display("tb_point_pair_distance_core failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Timeout with %0d distances outstanding", dist_expected.size());
        $display("tb_point_pair_distance_core failed");
        $finish;
    end

endmodule

>>> files.f
sv/ppd_pkg.sv
sv/ppd_sq_front.sv
sv/ppd_sqrt_pipe.sv
sv/point_pair_distance_core.sv
sim/tb_point_pair_distance_core.sv
